@@ rtl/bfdl_pkg.sv @@
// Shared constants, types and fault mapping functions for the battery fault debounce latch.
package bfdl_pkg;

   // Widths and defaults
   localparam int CountWidthDefault = 8;
   localparam int LimitWidth        = 8;
   localparam logic [LimitWidth-1:0] LimitReset = 8'd5;
   localparam int ProtWidth   = 16;
   localparam int TempWidth   = 12;
   localparam int ChgN        = 11;
   localparam int DisN        = 12;
   localparam int SysN        = 2;
   localparam int FaultN      = ChgN + DisN + SysN;
   localparam int DisBase     = ChgN;
   localparam int SysBase     = ChgN + DisN;
   localparam int FlagN       = 6;

   // Protection status bit positions
   localparam int ProtOv       = 0;
   localparam int ProtUv       = 1;
   localparam int ProtOcd1     = 2;
   localparam int ProtOcd2     = 3;
   localparam int ProtScd      = 4;
   localparam int ProtOcc1     = 5;
   localparam int ProtOcc2     = 8;
   localparam int ProtOtd      = 10;
   localparam int ProtOtc      = 11;
   localparam int ProtUtc      = 12;
   localparam int ProtUtd      = 13;
   localparam int ProtOverheat = 14;
   localparam int ProtOpenWire = 15;

   // Thermistor status bit positions
   localparam int TempTs0Otd = 0;
   localparam int TempTs0Otc = 1;
   localparam int TempTs0Utc = 2;
   localparam int TempTs0Utd = 3;
   localparam int TempTs1Otd = 4;
   localparam int TempTs1Otc = 5;
   localparam int TempTs1Utc = 6;
   localparam int TempTs1Utd = 7;
   localparam int TempTs2Otd = 8;
   localparam int TempTs2Otc = 9;
   localparam int TempTs2Utc = 10;
   localparam int TempTs2Utd = 11;

   // Pack flag bit positions
   localparam int FlagChgOv  = 0;
   localparam int FlagChgOc  = 1;
   localparam int FlagDisUv  = 2;
   localparam int FlagDisOc  = 3;
   localparam int FlagShort  = 4;
   localparam int FlagBatErr = 5;

   // Discharge latch positions that survive plugging in
   localparam int DisOcd1 = 1;
   localparam int DisOcd2 = 2;
   localparam int DisScd  = 3;

   typedef logic [FaultN-1:0] fault_vec_type;
   typedef logic [FlagN-1:0]  flag_vec_type;

   // Latches cleared on an unplugged tick: all charge latches
   localparam fault_vec_type UnplugClear = fault_vec_type'({ChgN{1'b1}});
   // Latches cleared on a plugged tick: discharge latches bar OCD1, OCD2 and SCD
   localparam fault_vec_type PlugClear =
      fault_vec_type'({12'hFF1, {ChgN{1'b0}}});

   // Status of one debounce cell after the current tick
   typedef struct packed {
      logic latch_in;
      logic set;
   } cell_stat_type;

   // Map the status words onto the per-fault active conditions
   function automatic fault_vec_type fault_conditions(
      input logic [ProtWidth-1:0] prot,
      input logic [TempWidth-1:0] temp,
      input logic                 plugged
   );
      fault_vec_type c;
      c = '0;
      c[0]  = plugged & prot[ProtOv];
      c[1]  = plugged & prot[ProtOcc1];
      c[2]  = plugged & prot[ProtOcc2];
      c[3]  = plugged & prot[ProtOtc];
      c[4]  = plugged & prot[ProtUtc];
      c[5]  = plugged & temp[TempTs0Otc];
      c[6]  = plugged & temp[TempTs0Utc];
      c[7]  = plugged & temp[TempTs1Otc];
      c[8]  = plugged & temp[TempTs1Utc];
      c[9]  = plugged & temp[TempTs2Otc];
      c[10] = plugged & temp[TempTs2Utc];
      c[DisBase+0]  = !plugged & prot[ProtUv];
      c[DisBase+1]  = !plugged & prot[ProtOcd1];
      c[DisBase+2]  = !plugged & prot[ProtOcd2];
      c[DisBase+3]  = !plugged & prot[ProtScd];
      c[DisBase+4]  = !plugged & prot[ProtOtd];
      c[DisBase+5]  = !plugged & prot[ProtUtd];
      c[DisBase+6]  = !plugged & temp[TempTs0Otd];
      c[DisBase+7]  = !plugged & temp[TempTs0Utd];
      c[DisBase+8]  = !plugged & temp[TempTs1Otd];
      c[DisBase+9]  = !plugged & temp[TempTs1Utd];
      c[DisBase+10] = !plugged & temp[TempTs2Otd];
      c[DisBase+11] = !plugged & temp[TempTs2Utd];
      c[SysBase+0] = prot[ProtOverheat];
      c[SysBase+1] = prot[ProtOpenWire];
      return c;
   endfunction

   // Pack flags raised by the faults that latch on this tick
   function automatic flag_vec_type fault_flags(input fault_vec_type set);
      flag_vec_type f;
      f = '0;
      f[FlagChgOv]  = set[0];
      f[FlagChgOc]  = set[1] | set[2];
      f[FlagDisUv]  = set[DisBase+0];
      f[FlagDisOc]  = set[DisBase+DisOcd1] | set[DisBase+DisOcd2];
      f[FlagShort]  = set[DisBase+DisScd];
      f[FlagBatErr] = set[SysBase+1];
      return f;
   endfunction

endpackage

@@ rtl/bfdl_chan_if.sv @@
// Request and response channel interfaces for the battery fault debounce latch.
interface bfdl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] protect_status;
   logic [11:0] temp_status;
   logic        charger_plugged;

   modport source (output valid, output protect_status, output temp_status,
                   output charger_plugged, input ready);
   modport sink   (input valid, input protect_status, input temp_status,
                   input charger_plugged, output ready);
endinterface

interface bfdl_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] charge_faults;
   logic [11:0] discharge_faults;
   logic [1:0]  system_faults;
   logic [5:0]  pack_flags;

   modport source (output valid, output charge_faults, output discharge_faults,
                   output system_faults, output pack_flags, input ready);
   modport sink   (input valid, input charge_faults, input discharge_faults,
                   input system_faults, input pack_flags, output ready);
endinterface

@@ rtl/bfdl_counter.sv @@
// One debounce cell: saturating consecutive-tick counter and its fault latch.
module bfdl_counter
   import bfdl_pkg::*;
#(
   parameter int CountWidth = CountWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  active,
   input  logic                  clear,
   input  logic [LimitWidth-1:0] limit,
   output cell_stat_type         stat
);

   localparam int CmpWidth = (CountWidth > LimitWidth) ? CountWidth : LimitWidth;

   logic [CountWidth-1:0] count_ff, count_in, count_inc;
   logic                  latch_ff, latch_in;
   logic                  over, set;

   // Count up, saturate, latch once the limit is passed
   always_comb begin
      count_inc = (count_ff == {CountWidth{1'b1}}) ? count_ff
                                                  : count_ff + CountWidth'(1);
      over      = CmpWidth'(count_inc) > CmpWidth'(limit);
      set       = active && over && !latch_ff;
      if (!active || set) begin
         count_in = '0;
      end else begin
         count_in = count_inc;
      end
      latch_in      = (latch_ff | set) & !clear;
      stat.latch_in = latch_in;
      stat.set      = set;
   end

   // Hold the state between ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         latch_ff <= 1'b0;
      end else if (advance) begin
         count_ff <= count_in;
         latch_ff <= latch_in;
      end
   end

endmodule

@@ rtl/bfdl_fault_bank.sv @@
// Bank of all debounce cells, latch clearing by charger state and sticky pack flags.
module bfdl_fault_bank
   import bfdl_pkg::*;
#(
   parameter int CountWidth = CountWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [ProtWidth-1:0]  protect_status,
   input  logic [TempWidth-1:0]  temp_status,
   input  logic                  charger_plugged,
   input  logic [LimitWidth-1:0] limit,
   output fault_vec_type         latches_in,
   output flag_vec_type          flags_in
);

   fault_vec_type active, clear, set;
   flag_vec_type  flags_ff;
   cell_stat_type stat [FaultN];

   // Decode conditions and pick the latches this charger state clears
   always_comb begin
      active = fault_conditions(protect_status, temp_status, charger_plugged);
      clear  = charger_plugged ? PlugClear : UnplugClear;
   end

   // One cell per fault
   for (genvar i = 0; i < FaultN; i++) begin : g_cell
      bfdl_counter #(.CountWidth(CountWidth)) u_counter (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .active  (active[i]),
         .clear   (clear[i]),
         .limit   (limit),
         .stat    (stat[i])
      );
      assign latches_in[i] = stat[i].latch_in;
      assign set[i]        = stat[i].set;
   end

   // Accumulate pack flags
   assign flags_in = flags_ff | fault_flags(set);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

endmodule

@@ rtl/battery_fault_debounce_latch_core.sv @@
// Top level of the battery fault debounce latch: input register, fault bank, result register.
// One poll item is accepted per clock cycle in steady state. An accepted item sits in the
// input register until the result register is free or being drained, and is then loaded into
// the result register, where it stays valid until the response channel takes it. Every
// fault counter and latch updates in the cycle the item leaves the input register, so items
// follow back to back; a held-off result stalls the input once both registers are full. The
// debounce limit is written through csr_write_enable/csr_write_data and resets to 5; write
// it only while the block is idle.
module battery_fault_debounce_latch_core
   import bfdl_pkg::*;
#(
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   bfdl_req_if.sink              req_chan,
   bfdl_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [LimitWidth-1:0] csr_write_data
);

   logic [LimitWidth-1:0] limit_ff;
   logic                  in_valid_ff;
   logic [ProtWidth-1:0]  in_prot_ff;
   logic [TempWidth-1:0]  in_temp_ff;
   logic                  in_plugged_ff;
   logic                  out_valid_ff;
   logic [ChgN-1:0]       out_chg_ff;
   logic [DisN-1:0]       out_dis_ff;
   logic [SysN-1:0]       out_sys_ff;
   flag_vec_type          out_flags_ff;
   logic                  out_free, advance;
   fault_vec_type         latches_in;
   flag_vec_type          flags_in;

   // Handshake: advance when the result register is free or being drained
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   // Hold the debounce limit
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_prot_ff    <= req_chan.protect_status;
         in_temp_ff    <= req_chan.temp_status;
         in_plugged_ff <= req_chan.charger_plugged;
      end
   end

   bfdl_fault_bank #(.CountWidth(COUNT_WIDTH)) u_bank (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .protect_status  (in_prot_ff),
      .temp_status     (in_temp_ff),
      .charger_plugged (in_plugged_ff),
      .limit           (limit_ff),
      .latches_in      (latches_in),
      .flags_in        (flags_in)
   );

   // Register the result item
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_chg_ff   <= latches_in[ChgN-1:0];
         out_dis_ff   <= latches_in[DisBase+DisN-1:DisBase];
         out_sys_ff   <= latches_in[SysBase+SysN-1:SysBase];
         out_flags_ff <= flags_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.charge_faults    = out_chg_ff;
   assign rsp_chan.discharge_faults = out_dis_ff;
   assign rsp_chan.system_faults    = out_sys_ff;
   assign rsp_chan.pack_flags       = out_flags_ff;

   // An unplugged tick leaves no charge latch standing
   a_unplug_clears: assert property (@(posedge clock) disable iff (reset)
      advance && !in_plugged_ff |=> rsp_chan.charge_faults == '0)
      else $error("charge latch survived an unplugged tick");

   // A plugged tick keeps only OCD1, OCD2 and SCD among discharge latches
   a_plug_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_plugged_ff |=> (rsp_chan.discharge_faults & 12'hFF1) == '0)
      else $error("discharge latch survived a plugged tick");

   // Pack flags only accumulate between consecutive results
   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(out_valid_ff) && out_valid_ff |->
         (rsp_chan.pack_flags & $past(rsp_chan.pack_flags)) == $past(rsp_chan.pack_flags))
      else $error("pack flag dropped");

   // An empty input register always takes an item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_chan.ready)
      else $error("input stalled while empty");

endmodule
